>>> rtl/core/kchm_pkg.sv
`default_nettype none

package kchm_pkg;

    localparam int KCHM_NUM_KEYS   = 4;
    localparam int KCHM_TIME_WIDTH = 16;

    localparam int TICK_INC_W  = 8;
    localparam int THRESH_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [TICK_INC_W-1:0] TICK_INC_RST     = 8'd10;
    localparam logic [THRESH_W-1:0]   PRESS_THR_RST    = 16'd20;
    localparam logic [THRESH_W-1:0]   HOLD_THR_RST     = 16'd1000;
    localparam logic [THRESH_W-1:0]   INTERVAL_THR_RST = 16'd300;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TICK_INC     = 2'd0,
        REG_PRESS_THR    = 2'd1,
        REG_HOLD_THR     = 2'd2,
        REG_INTERVAL_THR = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [TICK_INC_W-1:0] tick_inc;
        logic [THRESH_W-1:0]   press_thr;
        logic [THRESH_W-1:0]   hold_thr;
        logic [THRESH_W-1:0]   interval_thr;
    } cfg_t;

    typedef struct packed {
        logic press;
        logic hold;
        logic multi;
    } key_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/kchm_if.sv
`default_nettype none

interface kchm_in_if
    import kchm_pkg::*;
#(
    parameter int NUM_KEYS = KCHM_NUM_KEYS
) ();
    logic                valid;
    logic                ready;
    logic [NUM_KEYS-1:0] key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink   (input valid, input key_levels, output ready);
endinterface

interface kchm_out_if
    import kchm_pkg::*;
#(
    parameter int NUM_KEYS = KCHM_NUM_KEYS
) ();
    logic                valid;
    logic                ready;
    logic [NUM_KEYS-1:0] press_flags;
    logic [NUM_KEYS-1:0] hold_flags;
    logic [NUM_KEYS-1:0] multi_flags;

    modport source (output valid, output press_flags, output hold_flags,
                    output multi_flags, input ready);
    modport sink   (input valid, input press_flags, input hold_flags,
                    input multi_flags, output ready);
endinterface

`default_nettype wire

>>> rtl/core/kchm_cfg.sv
`default_nettype none

module kchm_cfg
    import kchm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_inc     <= TICK_INC_RST;
            cfg_reg.press_thr    <= PRESS_THR_RST;
            cfg_reg.hold_thr     <= HOLD_THR_RST;
            cfg_reg.interval_thr <= INTERVAL_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TICK_INC:     cfg_reg.tick_inc     <= cfg_wdata[TICK_INC_W-1:0];
                REG_PRESS_THR:    cfg_reg.press_thr    <= cfg_wdata[THRESH_W-1:0];
                REG_HOLD_THR:     cfg_reg.hold_thr     <= cfg_wdata[THRESH_W-1:0];
                REG_INTERVAL_THR: cfg_reg.interval_thr <= cfg_wdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/core/kchm_key.sv
`default_nettype none

module kchm_key
    import kchm_pkg::*;
#(
    parameter int TIME_WIDTH = KCHM_TIME_WIDTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,
    input  wire logic  down,
    input  wire cfg_t  cfg,
    output key_flags_t flags
);

    localparam int CMP_W = (TIME_WIDTH > THRESH_W) ? TIME_WIDTH : THRESH_W;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    typedef enum logic [2:0] {
        M_RELEASE  = 3'd0,
        M_DEBOUNCE = 3'd1,
        M_PRECLICK = 3'd2,
        M_INCLICK  = 3'd3,
        M_PRESS    = 3'd4,
        M_HOLD     = 3'd5,
        M_MULTI    = 3'd6
    } mode_t;

    mode_t                 mode_reg, mode_next;
    logic [TIME_WIDTH-1:0] held_reg, held_next;
    logic [TIME_WIDTH-1:0] gap_reg, gap_next;
    key_flags_t            seen_reg, seen_next;

    logic [TIME_WIDTH-1:0] held_base;
    logic [TIME_WIDTH:0]   held_sum;
    logic [TIME_WIDTH:0]   gap_sum;
    logic [TIME_WIDTH:0]   inc_ext;
    logic [CMP_W-1:0]      held_c, gap_c, press_c, hold_c, interval_c;
    logic                  above_press, above_hold, below_hold, gap_open;

    always_comb
    begin
        inc_ext   = (TIME_WIDTH+1)'(cfg.tick_inc);
        // debounce and hold keep the hold time across a release
        held_base = (!down && mode_reg != M_DEBOUNCE && mode_reg != M_HOLD) ?
                    '0 : held_reg;
        held_sum  = {1'b0, held_base} + inc_ext;
        gap_sum   = {1'b0, gap_reg} + inc_ext;

        if (down)
            held_next = held_sum[TIME_WIDTH] ? TIME_MAX : held_sum[TIME_WIDTH-1:0];
        else
            held_next = held_base;

        if (mode_reg == M_PRECLICK || mode_reg == M_INCLICK)
            gap_next = gap_sum[TIME_WIDTH] ? TIME_MAX : gap_sum[TIME_WIDTH-1:0];
        else
            gap_next = '0;

        held_c      = CMP_W'(held_next);
        gap_c       = CMP_W'(gap_next);
        press_c     = CMP_W'(cfg.press_thr);
        hold_c      = CMP_W'(cfg.hold_thr);
        interval_c  = CMP_W'(cfg.interval_thr);
        above_press = held_c > press_c;
        above_hold  = held_c > hold_c;
        below_hold  = held_c < hold_c;
        gap_open    = gap_c < interval_c;

        mode_next = mode_reg;
        seen_next = seen_reg;
        case (mode_reg)
            M_DEBOUNCE:
            begin
                if (!down)
                    mode_next = (above_press && below_hold) ? M_PRECLICK : M_RELEASE;
                else if (above_hold)
                    mode_next = M_HOLD;
            end
            M_PRECLICK:
            begin
                if (!gap_open)
                    mode_next = M_PRESS;
                else if (above_press)
                    mode_next = M_MULTI;
            end
            M_INCLICK:
            begin
                if (!gap_open)
                begin
                    seen_next.multi = 1'b1;
                    mode_next       = M_RELEASE;
                end
                else if (above_press)
                    mode_next = M_MULTI;
            end
            M_PRESS:
            begin
                seen_next.press = 1'b1;
                if (!down)
                    mode_next = M_RELEASE;
            end
            M_HOLD:
            begin
                if (!down)
                begin
                    seen_next.hold = 1'b1;
                    mode_next      = M_RELEASE;
                end
            end
            M_MULTI:
            begin
                if (!down)
                    mode_next = M_INCLICK;
            end
            default:
            begin
                // release, and the unused code
                seen_next = '0;
                mode_next = down ? M_DEBOUNCE : M_RELEASE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_RELEASE;
            held_reg <= '0;
            gap_reg  <= '0;
            seen_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            gap_reg  <= gap_next;
            seen_reg <= seen_next;
        end
    end

    assign flags = seen_reg;

endmodule

`default_nettype wire

>>> rtl/core/key_click_hold_multi_classifier_top.sv
// Key click / hold / multi-click classifier.
//
// keys  : one item per scan tick, key_levels bit i is the raw level of key i
//         (low means pressed). Accepted when keys.valid and keys.ready are high.
// flags : one item per scan tick with per-key press, hold and multi flags as
//         they stand after that tick's update.
// cfg   : write port (cfg_we, cfg_index, cfg_wdata) for tick increment and the
//         press, hold and interval thresholds; write only while idle.
//
// An accepted item passes through the input register, then through the per-key
// state update into the flag registers, before flags.valid goes high.
// Throughput is one item per cycle while flags.ready is high; the input
// register and the flag registers form a two-stage pipeline, so an item is
// taken while a result waits. When flags.ready is low the result holds and
// one more item is taken into the input register, after which keys.ready drops.
// Reset puts every key in release with zero timers and clear flags, and loads
// the registers with increment 10 and thresholds 20, 1000 and 300.
`default_nettype none

module key_click_hold_multi_classifier_top
    import kchm_pkg::*;
#(
    parameter int NUM_KEYS   = KCHM_NUM_KEYS,
    parameter int TIME_WIDTH = KCHM_TIME_WIDTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    kchm_in_if.sink                     keys,
    kchm_out_if.source                  flags,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t                cfg;
    logic                in_valid_reg;
    logic [NUM_KEYS-1:0] levels_reg;
    logic                out_valid_reg;
    logic                advance;
    key_flags_t          key_flags [NUM_KEYS];

    kchm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign advance    = in_valid_reg && (!out_valid_reg || flags.ready);
    assign keys.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (keys.ready)
                in_valid_reg <= keys.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (flags.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keys.valid && keys.ready)
            levels_reg <= keys.key_levels;
    end

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        kchm_key #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_key (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (advance),
            .down  (!levels_reg[k]),
            .cfg   (cfg),
            .flags (key_flags[k])
        );

        assign flags.press_flags[k] = key_flags[k].press;
        assign flags.hold_flags[k]  = key_flags[k].hold;
        assign flags.multi_flags[k] = key_flags[k].multi;
    end

    assign flags.valid = out_valid_reg;

    // a key reports at most one kind of event at a time
    a_one_event_per_key: assert property (@(posedge clk) disable iff (!rst_n)
        ((flags.press_flags & flags.hold_flags) == '0) &&
        ((flags.press_flags & flags.multi_flags) == '0) &&
        ((flags.hold_flags & flags.multi_flags) == '0))
        else $error("key reports more than one event");

    a_result_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without a staged item");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && flags.ready && !in_valid_reg |=> !out_valid_reg)
        else $error("result repeated after hand-off");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(levels_reg))
        else $error("staged item lost under stall");

endmodule

`default_nettype wire

>>> bench/tb_key_click_hold_multi_classifier_top.sv
`timescale 1ns / 1ps

module tb_key_click_hold_multi_classifier_top;
    import kchm_pkg::*;

    localparam int NK          = KCHM_NUM_KEYS;
    localparam int TW          = KCHM_TIME_WIDTH;
    localparam int DUT_LATENCY = 2;
    localparam int QUIET_LIMIT = 2000;
    localparam int SHORT_CAP   = 80;
    localparam int LONG_CAP    = 300;

    typedef enum logic [2:0] {
        KM_RELEASE  = 3'd0,
        KM_DEBOUNCE = 3'd1,
        KM_PRECLICK = 3'd2,
        KM_INCLICK  = 3'd3,
        KM_PRESS    = 3'd4,
        KM_HOLD     = 3'd5,
        KM_MULTI    = 3'd6
    } key_mode_t;

    typedef struct {
        logic [NK-1:0] press;
        logic [NK-1:0] hold;
        logic [NK-1:0] multi;
    } flag_set_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    cfg_reg_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    kchm_in_if  #(.NUM_KEYS(NK)) keys_ch ();
    kchm_out_if #(.NUM_KEYS(NK)) flags_ch ();

    key_click_hold_multi_classifier_top #(
        .NUM_KEYS   (NK),
        .TIME_WIDTH (TW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .keys      (keys_ch),
        .flags     (flags_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // shadow of the register file
    logic [TICK_INC_W-1:0] tick_inc;
    logic [THRESH_W-1:0]   press_thr;
    logic [THRESH_W-1:0]   hold_thr;
    logic [THRESH_W-1:0]   interval_thr;

    // per-key shadow state
    key_mode_t     kmode [NK];
    logic [TW-1:0] held_time [NK];
    logic [TW-1:0] gap_time [NK];
    logic [NK-1:0] press_latch;
    logic [NK-1:0] hold_latch;
    logic [NK-1:0] multi_latch;

    flag_set_t flags_expected [$];
    bit        key_plan [NK][$];

    int  errors = 0;
    int  quiet_cycles = 0;
    bit  gaps_en = 1'b1;
    bit  stalls_en = 1'b1;
    int  stall_left = 0;

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [TW-1:0] sat_add(logic [TW-1:0] t, logic [TICK_INC_W-1:0] inc);
        logic [TW:0] s;
        s = {1'b0, t} + inc;
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    function automatic void reset_key_model();
        tick_inc     = TICK_INC_RST;
        press_thr    = PRESS_THR_RST;
        hold_thr     = HOLD_THR_RST;
        interval_thr = INTERVAL_THR_RST;
        press_latch  = '0;
        hold_latch   = '0;
        multi_latch  = '0;
        for (int k = 0; k < NK; k++)
        begin
            kmode[k]     = KM_RELEASE;
            held_time[k] = '0;
            gap_time[k]  = '0;
        end
    endfunction

    function automatic void predict_key_flags(logic [NK-1:0] lv);
        bit        down;
        key_mode_t m;
        flag_set_t fs;
        for (int k = 0; k < NK; k++)
        begin
            down = !lv[k];
            m = kmode[k];
            if (!down && m != KM_DEBOUNCE && m != KM_HOLD)
                held_time[k] = '0;
            if (down)
                held_time[k] = sat_add(held_time[k], tick_inc);
            if (m == KM_PRECLICK || m == KM_INCLICK)
                gap_time[k] = sat_add(gap_time[k], tick_inc);
            else
                gap_time[k] = '0;
            case (m)
                KM_DEBOUNCE:
                begin
                    if (held_time[k] > hold_thr)
                        kmode[k] = KM_HOLD;
                    if (!down)
                    begin
                        if (held_time[k] > press_thr && held_time[k] < hold_thr)
                            kmode[k] = KM_PRECLICK;
                        else
                            kmode[k] = KM_RELEASE;
                    end
                end
                KM_PRECLICK:
                begin
                    if (gap_time[k] < interval_thr)
                    begin
                        if (held_time[k] > press_thr)
                            kmode[k] = KM_MULTI;
                    end
                    else
                        kmode[k] = KM_PRESS;
                end
                KM_INCLICK:
                begin
                    if (gap_time[k] < interval_thr)
                    begin
                        if (held_time[k] > press_thr)
                            kmode[k] = KM_MULTI;
                    end
                    else
                    begin
                        multi_latch[k] = 1'b1;
                        kmode[k] = KM_RELEASE;
                    end
                end
                KM_PRESS:
                begin
                    press_latch[k] = 1'b1;
                    if (!down)
                        kmode[k] = KM_RELEASE;
                end
                KM_HOLD:
                begin
                    if (!down)
                    begin
                        hold_latch[k] = 1'b1;
                        kmode[k] = KM_RELEASE;
                    end
                end
                KM_MULTI:
                begin
                    if (!down)
                        kmode[k] = KM_INCLICK;
                end
                default:
                begin
                    press_latch[k] = 1'b0;
                    hold_latch[k]  = 1'b0;
                    multi_latch[k] = 1'b0;
                    kmode[k] = down ? KM_DEBOUNCE : KM_RELEASE;
                end
            endcase
        end
        fs.press = press_latch;
        fs.hold  = hold_latch;
        fs.multi = multi_latch;
        flags_expected.push_back(fs);
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t MISMATCH %s", $realtime, msg);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        flag_set_t fs;
        if (rst_n && flags_ch.valid && flags_ch.ready)
        begin
            if (flags_expected.size() == 0)
                report_mismatch($sformatf("unexpected flags item p=%h h=%h m=%h",
                    flags_ch.press_flags, flags_ch.hold_flags, flags_ch.multi_flags));
            else
            begin
                fs = flags_expected.pop_front();
                if (flags_ch.press_flags !== fs.press)
                    report_mismatch($sformatf("press_flags got %h exp %h",
                        flags_ch.press_flags, fs.press));
                if (flags_ch.hold_flags !== fs.hold)
                    report_mismatch($sformatf("hold_flags got %h exp %h",
                        flags_ch.hold_flags, fs.hold));
                if (flags_ch.multi_flags !== fs.multi)
                    report_mismatch($sformatf("multi_flags got %h exp %h",
                        flags_ch.multi_flags, fs.multi));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((keys_ch.valid && keys_ch.ready) || (flags_ch.valid && flags_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_key_click_hold_multi_classifier_top: errors");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        logic nxt;
        nxt = 1'b1;
        if (stall_left > 0)
        begin
            stall_left--;
            nxt = 1'b0;
        end
        else if (stalls_en && $urandom_range(0, 99) < 15)
        begin
            stall_left = pick_pause() - 1;
            nxt = 1'b0;
        end
        flags_ch.ready <= nxt;
    end

    task automatic send_key_item(logic [NK-1:0] lv);
        int n;
        if (gaps_en && $urandom_range(0, 99) < 20)
        begin
            n = pick_pause();
            @(negedge clk) keys_ch.valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        keys_ch.valid      <= 1'b1;
        keys_ch.key_levels <= lv;
        @(posedge clk);
        while (!keys_ch.ready)
            @(posedge clk);
        predict_key_flags(lv);
    endtask

    task automatic wait_flags_drained();
        @(negedge clk) keys_ch.valid <= 1'b0;
        while (flags_expected.size() != 0)
            @(negedge clk);
        repeat (DUT_LATENCY + 2) @(negedge clk);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk) cfg_we <= 1'b0;
        case (idx)
            REG_TICK_INC:     tick_inc     = val[TICK_INC_W-1:0];
            REG_PRESS_THR:    press_thr    = val[THRESH_W-1:0];
            REG_HOLD_THR:     hold_thr     = val[THRESH_W-1:0];
            REG_INTERVAL_THR: interval_thr = val[THRESH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_timing(int inc, int pthr, int hthr, int ithr);
        wait_flags_drained();
        cfg_write(REG_TICK_INC, CFG_DATA_W'(inc));
        cfg_write(REG_PRESS_THR, CFG_DATA_W'(pthr));
        cfg_write(REG_HOLD_THR, CFG_DATA_W'(hthr));
        cfg_write(REG_INTERVAL_THR, CFG_DATA_W'(ithr));
    endtask

    function automatic void plan_push(int k, bit up, int n);
        repeat (n) key_plan[k].push_back(up);
    endfunction

    function automatic int cap(int v, int hi);
        return (v > hi) ? hi : v;
    endfunction

    // ticks until the hold time passes thr
    function automatic int ticks_over(int unsigned thr);
        if (tick_inc == 0)
            return 1;
        return thr / tick_inc + 1;
    endfunction

    function automatic int click_len();
        int lo, hi;
        lo = cap(ticks_over(press_thr), SHORT_CAP);
        hi = cap(ticks_over(hold_thr) - 1, SHORT_CAP);
        if (hi < lo)
            hi = lo;
        return $urandom_range(lo, hi);
    endfunction

    function automatic int settle_len();
        return cap(ticks_over(interval_thr) + $urandom_range(1, 4), LONG_CAP);
    endfunction

    // append one well-formed gesture (or some noise) to a key's schedule
    function automatic void fill_plan(int k);
        int r, iv, clicks;
        iv = cap(ticks_over(interval_thr), SHORT_CAP);
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            plan_push(k, 1'b0, click_len());
            plan_push(k, 1'b1, settle_len());
        end
        else if (r < 45)
        begin
            plan_push(k, 1'b0, cap(ticks_over(hold_thr) + $urandom_range(0, 2), LONG_CAP));
            plan_push(k, 1'b1, $urandom_range(1, 3));
        end
        else if (r < 75)
        begin
            clicks = $urandom_range(2, 3);
            plan_push(k, 1'b0, click_len());
            for (int c = 1; c < clicks; c++)
            begin
                plan_push(k, 1'b1, $urandom_range(1, (iv > 2) ? iv - 1 : 1));
                plan_push(k, 1'b0, click_len());
            end
            plan_push(k, 1'b1, settle_len());
        end
        else if (r < 90)
        begin
            repeat ($urandom_range(1, 6)) plan_push(k, 1'($urandom_range(0, 1)), 1);
        end
        else
            plan_push(k, 1'b1, $urandom_range(1, 5));
    endfunction

    function automatic void clear_plans();
        for (int k = 0; k < NK; k++)
            key_plan[k].delete();
    endfunction

    task automatic run_ticks(int n);
        logic [NK-1:0] lv;
        for (int i = 0; i < n; i++)
        begin
            for (int k = 0; k < NK; k++)
            begin
                if (key_plan[k].size() == 0)
                    fill_plan(k);
                lv[k] = key_plan[k].pop_front();
            end
            send_key_item(lv);
        end
        clear_plans();
    endtask

    // play the scheduled levels; a key with nothing left stays up
    task automatic run_plans();
        logic [NK-1:0] lv;
        bit busy;
        busy = 1'b1;
        while (busy)
        begin
            busy = 1'b0;
            for (int k = 0; k < NK; k++)
                if (key_plan[k].size() != 0)
                    busy = 1'b1;
            if (busy)
            begin
                for (int k = 0; k < NK; k++)
                    lv[k] = (key_plan[k].size() != 0) ? key_plan[k].pop_front() : 1'b1;
                send_key_item(lv);
            end
        end
    endtask

    task automatic test_directed_gestures();
        set_timing(10, 15, 60, 25);
        // short press, long hold, double click, chatter
        plan_push(0, 1'b0, 3);
        plan_push(0, 1'b1, 7);
        plan_push(1, 1'b0, 8);
        plan_push(1, 1'b1, 2);
        plan_push(2, 1'b0, 3);
        plan_push(2, 1'b1, 1);
        plan_push(2, 1'b0, 3);
        plan_push(2, 1'b1, 5);
        repeat (3)
        begin
            plan_push(3, 1'b0, 1);
            plan_push(3, 1'b1, 1);
        end
        run_plans();
    endtask

    task automatic test_directed_edges();
        // released on the tick the hold time is above threshold: no hold flag
        set_timing(10, 15, 5, 25);
        plan_push(0, 1'b0, 1);
        plan_push(0, 1'b1, 3);
        run_plans();
        // hold time exactly at hold threshold on release
        set_timing(10, 0, 20, 25);
        plan_push(1, 1'b0, 2);
        plan_push(1, 1'b1, 2);
        run_plans();
        // zero increment: timers stay at zero
        set_timing(0, 0, 0, 0);
        plan_push(2, 1'b0, 3);
        plan_push(2, 1'b1, 1);
        plan_push(3, 1'b0, 1);
        plan_push(3, 1'b1, 1);
        run_plans();
    endtask

    task automatic test_default_timing();
        set_timing(TICK_INC_RST, PRESS_THR_RST, HOLD_THR_RST, INTERVAL_THR_RST);
        run_ticks(60);
    endtask

    task automatic test_fine_timing();
        gaps_en = 1'b0;
        stalls_en = 1'b0;
        set_timing(1, 2, 20, 8);
        run_ticks(60);
        gaps_en = 1'b1;
        stalls_en = 1'b1;
    endtask

    task automatic test_zero_thresholds();
        set_timing(255, 0, 0, 0);
        run_ticks(25);
    endtask

    task automatic test_zero_increment();
        set_timing(0, 20, 1000, 300);
        run_ticks(20);
    endtask

    task automatic test_max_thresholds();
        set_timing(255, 65535, 65535, 65535);
        run_ticks(30);
    endtask

    task automatic test_random_timing();
        int pthr;
        repeat (2)
        begin
            pthr = $urandom_range(0, 100);
            set_timing($urandom_range(1, 40), pthr, pthr + $urandom_range(10, 600),
                       $urandom_range(0, 400));
            run_ticks(30);
        end
    endtask

    task automatic test_timer_saturation();
        // hold time clips above hold threshold, gap time clips at interval threshold
        set_timing(254, 0, 65534, 65535);
        plan_push(0, 1'b0, 260);
        plan_push(0, 1'b1, 3);
        plan_push(1, 1'b0, 2);
        plan_push(1, 1'b1, 262);
        run_plans();
        // clipped hold time equals the threshold: back to release
        set_timing(254, 0, 65535, 100);
        plan_push(2, 1'b0, 260);
        plan_push(2, 1'b1, 3);
        run_plans();
    endtask

    task automatic test_drain_pause();
        set_timing(5, 10, 150, 40);
        run_ticks(15);
        wait_flags_drained();
        run_ticks(15);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        keys_ch.valid      = 1'b0;
        keys_ch.key_levels = '1;
        flags_ch.ready     = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_TICK_INC;
        cfg_wdata          = '0;
        reset_key_model();
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_directed_gestures();
        test_directed_edges();
        test_default_timing();
        test_fine_timing();
        test_zero_thresholds();
        test_zero_increment();
        test_max_thresholds();
        test_random_timing();
        test_timer_saturation();
        test_drain_pause();

        wait_flags_drained();
        if (errors == 0)
            $display("tb_key_click_hold_multi_classifier_top: clean");
        else
            $display("tb_key_click_hold_multi_classifier_top: errors");
        $finish;
    end

endmodule
